### rtl/efcrc_pkg.sv
// Shared constants, command types and the byte-wide CRC update for the frame CRC core.
`timescale 1ns / 1ps

package efcrc_pkg;

   // Field widths of the configuration registers and channels.
   localparam int unsigned ADDR_W       = 48;
   localparam int unsigned LEN_W        = 16;
   localparam int unsigned CSR_DATA_W   = 48;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned CRC_W        = 32;
   localparam int unsigned HDR_INDEX_W  = 4;

   // Header is destination, source and length: fourteen bytes.
   localparam int unsigned HDR_BYTES    = 14;
   localparam int unsigned HDR_W        = 2 * ADDR_W + LEN_W;
   localparam logic [HDR_INDEX_W-1:0] HDR_LAST_INDEX = HDR_INDEX_W'(HDR_BYTES - 1);

   // The 32 zero bits that close the division are fed as four zero bytes.
   localparam logic [HDR_INDEX_W-1:0] FLUSH_LAST_INDEX = HDR_INDEX_W'(CRC_W / BYTE_W - 1);

   localparam int unsigned MIN_PAYLOAD_DEFAULT = 46;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;

   // Register reset values.
   localparam logic [ADDR_W-1:0] DEST_RESET = 48'h8000_FF60_2CDC;
   localparam logic [ADDR_W-1:0] SRC_RESET  = 48'h8000_FE85_3A5F;
   localparam logic [LEN_W-1:0]  LEN_RESET  = 16'h0040;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEN  = 2'd2;

   typedef enum logic [1:0] {
      CRC_HOLD,
      CRC_CLEAR,
      CRC_FEED
   } crc_op_type;

   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_LATCH,
      SRC_HEADER,
      SRC_ZERO
   } byte_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      crc_op_type              crc_op;
      byte_src_type            src;
      logic [HDR_INDEX_W-1:0]  hdr_index;
      logic                    latch_byte;
      logic                    load_out;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // Shift eight message bits, most significant first, into the remainder.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] r;
      logic             top;
      r = crc;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         top = r[CRC_W-1];
         r   = {r[CRC_W-2:0], data[k]};
         if (top) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

endpackage

### rtl/efcrc_if.sv
// Valid/ready channel interfaces for the payload bytes and the CRC results.
`timescale 1ns / 1ps

interface efcrc_req_if;
   logic                             valid;
   logic                             ready;
   logic [efcrc_pkg::BYTE_W-1:0]     data_byte;
   logic                             last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface efcrc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [efcrc_pkg::CRC_W-1:0]      crc_value;

   modport source (output valid, output crc_value, input ready);
   modport sink   (input valid, input crc_value, output ready);
endinterface

### rtl/efcrc_dp.sv
// Datapath: header registers, CRC remainder register and the result output register.
`timescale 1ns / 1ps

module efcrc_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [efcrc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [efcrc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic [efcrc_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [efcrc_pkg::CRC_W-1:0]          rsp_crc_value,
   input  efcrc_pkg::dp_cmd_type                cmd,
   output efcrc_pkg::dp_status_type             status
);

   logic [efcrc_pkg::ADDR_W-1:0] dest_ff;
   logic [efcrc_pkg::ADDR_W-1:0] src_ff;
   logic [efcrc_pkg::LEN_W-1:0]  len_ff;
   logic [efcrc_pkg::BYTE_W-1:0] byte_ff;
   logic [efcrc_pkg::CRC_W-1:0]  crc_ff;
   logic [efcrc_pkg::CRC_W-1:0]  crc_in;
   logic                         rsp_valid_ff;
   logic [efcrc_pkg::CRC_W-1:0]  rsp_crc_ff;

   logic [efcrc_pkg::HDR_W-1:0]  hdr_word;
   logic [6:0]                   hdr_shift;
   logic [efcrc_pkg::BYTE_W-1:0] hdr_byte;
   logic [efcrc_pkg::BYTE_W-1:0] feed_byte;

   // Configuration registers; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff <= efcrc_pkg::DEST_RESET;
         src_ff  <= efcrc_pkg::SRC_RESET;
         len_ff  <= efcrc_pkg::LEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            efcrc_pkg::CSR_DEST: dest_ff <= csr_write_data;
            efcrc_pkg::CSR_SRC:  src_ff  <= csr_write_data;
            efcrc_pkg::CSR_LEN:  len_ff  <= csr_write_data[efcrc_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Header byte selected by index, most significant byte first.
   assign hdr_word  = {dest_ff, src_ff, len_ff};
   assign hdr_shift = {efcrc_pkg::HDR_LAST_INDEX - cmd.hdr_index, 3'b000};
   assign hdr_byte  = efcrc_pkg::BYTE_W'(hdr_word >> hdr_shift);

   // Message byte fed into the remainder this cycle.
   always_comb begin
      case (cmd.src)
         efcrc_pkg::SRC_INPUT:  feed_byte = req_data_byte;
         efcrc_pkg::SRC_LATCH:  feed_byte = byte_ff;
         efcrc_pkg::SRC_HEADER: feed_byte = hdr_byte;
         default:               feed_byte = '0;
      endcase
   end

   always_comb begin
      case (cmd.crc_op)
         efcrc_pkg::CRC_CLEAR: crc_in = '0;
         efcrc_pkg::CRC_FEED:  crc_in = efcrc_pkg::crc_byte(crc_ff, feed_byte);
         default:              crc_in = crc_ff;
      endcase
   end

   // Remainder and the byte held while the header goes in.
   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (cmd.latch_byte) begin
         byte_ff <= req_data_byte;
      end
   end

   // Output register: holds a finished result until the sink takes the transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_crc_ff <= crc_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_crc_value   = rsp_crc_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

### rtl/efcrc_ctrl.sv
// Controller: frame sequencing through header, payload, padding and flush.
`timescale 1ns / 1ps

module efcrc_ctrl #(
   parameter int unsigned MIN_PAYLOAD = efcrc_pkg::MIN_PAYLOAD_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_last,
   output logic                      req_ready,
   output efcrc_pkg::dp_cmd_type     cmd,
   input  efcrc_pkg::dp_status_type  status
);

   localparam int unsigned CNT_W = $clog2(MIN_PAYLOAD + 1);
   localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_PAYLOAD);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
   localparam logic [efcrc_pkg::HDR_INDEX_W-1:0] ONE_STEP = efcrc_pkg::HDR_INDEX_W'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEADER,
      S_PAYLOAD,
      S_PAD,
      S_FLUSH,
      S_DONE
   } state_type;

   state_type                             state_ff, state_in;
   logic [CNT_W-1:0]                      count_ff, count_in;
   logic [efcrc_pkg::HDR_INDEX_W-1:0]     step_ff, step_in;
   logic                                  open_ff, open_in;
   logic                                  last_ff, last_in;
   logic [CNT_W-1:0]                      count_inc;
   logic                                  accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign count_inc = (count_ff < MIN_CNT) ? count_ff + ONE_CNT : count_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      open_in        = open_ff;
      last_in        = last_ff;
      cmd.crc_op     = efcrc_pkg::CRC_HOLD;
      cmd.src        = efcrc_pkg::SRC_ZERO;
      cmd.hdr_index  = step_ff;
      cmd.latch_byte = 1'b0;
      cmd.load_out   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && open_ff) begin
               // Frame already open: the byte goes straight into the remainder.
               cmd.crc_op = efcrc_pkg::CRC_FEED;
               cmd.src    = efcrc_pkg::SRC_INPUT;
               count_in   = count_inc;
               step_in    = '0;
               if (req_last) begin
                  state_in = (count_inc < MIN_CNT) ? S_PAD : S_FLUSH;
               end
            end else if (accept) begin
               // First byte of a frame: clear and send the header ahead of it.
               cmd.crc_op     = efcrc_pkg::CRC_CLEAR;
               cmd.latch_byte = 1'b1;
               open_in        = 1'b1;
               last_in        = req_last;
               count_in       = '0;
               step_in        = '0;
               state_in       = S_HEADER;
            end
         end
         S_HEADER: begin
            cmd.crc_op = efcrc_pkg::CRC_FEED;
            cmd.src    = efcrc_pkg::SRC_HEADER;
            step_in    = step_ff + ONE_STEP;
            if (step_ff == efcrc_pkg::HDR_LAST_INDEX) begin
               state_in = S_PAYLOAD;
            end
         end
         S_PAYLOAD: begin
            cmd.crc_op = efcrc_pkg::CRC_FEED;
            cmd.src    = efcrc_pkg::SRC_LATCH;
            count_in   = ONE_CNT;
            step_in    = '0;
            if (last_ff) begin
               state_in = (ONE_CNT < MIN_CNT) ? S_PAD : S_FLUSH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            cmd.crc_op = efcrc_pkg::CRC_FEED;
            cmd.src    = efcrc_pkg::SRC_ZERO;
            count_in   = count_ff + ONE_CNT;
            if (count_ff + ONE_CNT == MIN_CNT) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            cmd.crc_op = efcrc_pkg::CRC_FEED;
            cmd.src    = efcrc_pkg::SRC_ZERO;
            step_in    = step_ff + ONE_STEP;
            if (step_ff == efcrc_pkg::FLUSH_LAST_INDEX) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Wait for the output register to be free, then close the frame.
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               open_in      = 1'b0;
               count_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         step_ff  <= '0;
         open_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         open_ff  <= open_in;
         last_ff  <= last_in;
      end
   end

`ifndef SYNTHESIS
   // A result is only loaded when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded while output register occupied");

   // The payload count saturates at the minimum payload length.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= MIN_CNT)
      else $error("payload count above minimum payload");

   // The flush only starts once the payload has been padded to full length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> (count_ff == MIN_CNT))
      else $error("flush entered with short payload");

   // Header and payload work happens inside an open frame.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HEADER || state_ff == S_PAYLOAD || state_ff == S_PAD) |-> open_ff)
      else $error("frame work without an open frame");
`endif

endmodule

### rtl/ethernet_frame_crc32_core.sv
// Top level of the frame CRC-32 core: controller and datapath joined by commands.
// A frame's first byte is accepted and latched, the 14 header bytes go in, then the byte itself.
// Further payload bytes are accepted one per cycle, each fed in its accept cycle.
// After the last byte: pad bytes one per cycle up to MIN_PAYLOAD, then four zero flush bytes,
// then the result enters the output register from the done state, once it is free.
// Reset is synchronous and active high; configuration returns to its reset values.
`timescale 1ns / 1ps

module ethernet_frame_crc32_core #(
   parameter int unsigned MIN_PAYLOAD = efcrc_pkg::MIN_PAYLOAD_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   efcrc_req_if.sink                          req_chan,
   efcrc_rsp_if.source                        rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [efcrc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [efcrc_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   efcrc_pkg::dp_cmd_type    cmd;
   efcrc_pkg::dp_status_type status;

   // Frame sequencing.
   efcrc_ctrl #(
      .MIN_PAYLOAD (MIN_PAYLOAD)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_byte),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Remainder, header and output storage.
   efcrc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data_byte    (req_chan.data_byte),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_crc_value    (rsp_chan.crc_value),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
